[hdl/pcmm_pkg.sv]
// Package for the per-channel min/max/mean block.
// Widths, table layout and register map; no dependencies.
`default_nettype none
package pcmm_pkg;

  localparam int ChannelCount    = 16;
  localparam int ChanWidth       = 4;
  localparam int SampleWidth     = 16;
  localparam int SumWidth        = 32;
  localparam int CfgWidth        = 16;
  localparam int MaxBlockSamples = 65535;
  localparam int EntryWidth      = 2 * SampleWidth + SumWidth;
  localparam int DivSteps        = SumWidth;
  localparam int DivCntWidth     = $clog2(DivSteps);

  localparam int ApbAddrWidth    = 3;
  localparam int ApbDataWidth    = 32;
  localparam logic RegSamplesPerBlock = 1'b0;

  localparam logic [SampleWidth-1:0] SampleMax = {SampleWidth{1'b1}};

  typedef struct packed {
    logic [SampleWidth-1:0] minimum;
    logic [SampleWidth-1:0] maximum;
    logic [SumWidth-1:0]    sum;
  } entry_t;

endpackage
`default_nettype wire

[hdl/pcmm_if.sv]
// Request channels of the per-channel min/max/mean block.
// Depends on pcmm_pkg.
`default_nettype none
interface pcmm_in_if;
  logic                               valid;
  logic                               ready;
  logic [pcmm_pkg::ChanWidth-1:0]     channel;
  logic [pcmm_pkg::SampleWidth-1:0]   sample;
  logic                               first_pass;
  logic                               last_pass;

  modport source (output valid, channel, sample, first_pass, last_pass, input ready);
  modport sink   (input valid, channel, sample, first_pass, last_pass, output ready);
endinterface

interface pcmm_out_if;
  logic                               valid;
  logic                               ready;
  logic [pcmm_pkg::ChanWidth-1:0]     channel_out;
  logic [pcmm_pkg::SampleWidth-1:0]   minimum;
  logic [pcmm_pkg::SampleWidth-1:0]   maximum;
  logic [pcmm_pkg::SumWidth-1:0]      running_sum;
  logic                               report_valid;
  logic [pcmm_pkg::SampleWidth-1:0]   average;
  logic [pcmm_pkg::SampleWidth-1:0]   below_average;
  logic [pcmm_pkg::SampleWidth-1:0]   above_average;

  modport source (output valid, channel_out, minimum, maximum, running_sum, report_valid,
                  average, below_average, above_average, input ready);
  modport sink   (input valid, channel_out, minimum, maximum, running_sum, report_valid,
                  average, below_average, above_average, output ready);
endinterface
`default_nettype wire

[hdl/pcmm_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pcmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     req_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule
`default_nettype wire

[hdl/per_channel_min_max_mean.sv]
// Per-channel running minimum, maximum, sum and block average.
// Depends on pcmm_pkg, pcmm_if.sv (pcmm_in_if, pcmm_out_if) and pcmm_ram.
//
// Usage:
//   in_i carries one converter sample per request, tagged with its channel.
//   first_pass clears the channel entry before the sample is folded in;
//   last_pass adds the average (sum / samples_per_block, truncated and
//   saturated to 16 bits) and the distances from it to min and max.
//   out_o returns exactly one request per input request, in order.
//   Register samples_per_block sits at APB byte address 0 (reset 1, 0 acts
//   as 1); write it only while the block is idle.
// Timing:
//   One request at a time. The channel entry is read from the table RAM
//   at acceptance, updated and written back in the next cycle (StUpdate).
//   A request without last_pass then goes to StPush; with last_pass the
//   radix-2 divider (StDiv) runs first. in_i is ready again as soon as the
//   result enters the output register from StPush.
// Reset: control clears at once, table contents stay undefined until a
//   first_pass sample writes a channel. A stalled out_o holds its result;
//   one more request is taken and processed, then waits for the register.
`default_nettype none
module per_channel_min_max_mean (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  pcmm_in_if.sink                                  in_i,
  pcmm_out_if.source                               out_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pcmm_pkg::ApbAddrWidth-1:0]   paddr,
  input  wire logic [pcmm_pkg::ApbDataWidth-1:0]   pwdata,
  output      logic [pcmm_pkg::ApbDataWidth-1:0]   prdata,
  output      logic                                pready
);

  typedef enum logic [1:0] {StIdle, StUpdate, StDiv, StPush} state_e;

  localparam int SW = pcmm_pkg::SampleWidth;
  localparam int UW = pcmm_pkg::SumWidth;

  state_e                              state_q, state_d;
  logic [pcmm_pkg::ChanWidth-1:0]      ch_q, ch_d;
  logic [SW-1:0]                       smp_q, smp_d;
  logic                                first_q, first_d;
  logic                                last_q, last_d;
  logic [SW-1:0]                       min_q, min_d;
  logic [SW-1:0]                       max_q, max_d;
  logic [UW-1:0]                       sum_q, sum_d;
  logic [UW-1:0]                       quo_q, quo_d;
  logic [SW-1:0]                       rem_q, rem_d;
  logic [pcmm_pkg::DivCntWidth-1:0]    cnt_q, cnt_d;
  logic [pcmm_pkg::CfgWidth-1:0]       spb_q, spb_d;

  logic                                ov_q, ov_d;
  logic [pcmm_pkg::ChanWidth-1:0]      o_ch_q, o_ch_d;
  logic [SW-1:0]                       o_min_q, o_min_d;
  logic [SW-1:0]                       o_max_q, o_max_d;
  logic [UW-1:0]                       o_sum_q, o_sum_d;
  logic                                o_rep_q, o_rep_d;
  logic [SW-1:0]                       o_avg_q, o_avg_d;
  logic [SW-1:0]                       o_blw_q, o_blw_d;
  logic [SW-1:0]                       o_abv_q, o_abv_d;

  logic                                in_acc;
  logic                                ram_req, ram_we;
  logic [pcmm_pkg::ChanWidth-1:0]      ram_addr;
  pcmm_pkg::entry_t                    ram_wdata, ram_rdata, old_e;
  logic [SW-1:0]                       divisor;
  logic [SW:0]                         rem_sh;
  logic [SW+1:0]                       rem_diff;
  logic                                div_ge;
  logic [SW-1:0]                       avg;
  logic                                cfg_wr;

  // table RAM: read at acceptance, write back in StUpdate; the next read
  // only happens after StPush, so no forwarding is needed
  pcmm_ram #(
    .Width (pcmm_pkg::EntryWidth),
    .Depth (pcmm_pkg::ChannelCount)
  ) u_table (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle);
  assign ram_we    = (state_q == StUpdate);
  assign ram_req   = in_acc || ram_we;
  assign ram_addr  = ram_we ? ch_q : in_i.channel;
  assign ram_wdata = '{minimum: min_d, maximum: max_d, sum: sum_d};

  always_comb begin
    if (first_q) begin
      old_e = '{minimum: pcmm_pkg::SampleMax, maximum: '0, sum: '0};
    end else begin
      old_e = ram_rdata;
    end
  end

  always_comb begin
    if (spb_q == '0) begin
      divisor = SW'(1);
    end else if (32'(spb_q) > pcmm_pkg::MaxBlockSamples) begin
      divisor = SW'(pcmm_pkg::MaxBlockSamples);
    end else begin
      divisor = spb_q;
    end
  end

  assign rem_sh   = {rem_q, quo_q[UW-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, divisor};
  assign div_ge   = !rem_diff[SW+1];
  assign avg      = (quo_q[UW-1:SW] != '0) ? pcmm_pkg::SampleMax : quo_q[SW-1:0];

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == pcmm_pkg::RegSamplesPerBlock) begin
      prdata = {{(pcmm_pkg::ApbDataWidth - pcmm_pkg::CfgWidth){1'b0}}, spb_q};
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    smp_d   = smp_q;
    first_d = first_q;
    last_d  = last_q;
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    spb_d   = spb_q;
    ov_d    = ov_q;
    o_ch_d  = o_ch_q;
    o_min_d = o_min_q;
    o_max_d = o_max_q;
    o_sum_d = o_sum_q;
    o_rep_d = o_rep_q;
    o_avg_d = o_avg_q;
    o_blw_d = o_blw_q;
    o_abv_d = o_abv_q;

    if (cfg_wr && paddr[2] == pcmm_pkg::RegSamplesPerBlock) begin
      spb_d = pwdata[pcmm_pkg::CfgWidth-1:0];
    end

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          ch_d    = in_i.channel;
          smp_d   = in_i.sample;
          first_d = in_i.first_pass;
          last_d  = in_i.last_pass;
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        min_d = (smp_q < old_e.minimum) ? smp_q : old_e.minimum;
        max_d = (smp_q > old_e.maximum) ? smp_q : old_e.maximum;
        sum_d = old_e.sum + UW'(smp_q);
        quo_d = sum_d;
        rem_d = '0;
        cnt_d = '0;
        state_d = last_q ? StDiv : StPush;
      end
      StDiv: begin
        quo_d = {quo_q[UW-2:0], div_ge};
        rem_d = div_ge ? rem_diff[SW-1:0] : rem_sh[SW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == pcmm_pkg::DivCntWidth'(pcmm_pkg::DivSteps - 1)) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          o_ch_d  = ch_q;
          o_min_d = min_q;
          o_max_d = max_q;
          o_sum_d = sum_q;
          o_rep_d = last_q;
          o_avg_d = last_q ? avg : '0;
          o_blw_d = (last_q && avg > min_q) ? avg - min_q : '0;
          o_abv_d = (last_q && max_q > avg) ? max_q - avg : '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      spb_q   <= pcmm_pkg::CfgWidth'(1);
      ov_q    <= 1'b0;
      ch_q    <= '0;
      smp_q   <= '0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
      min_q   <= '0;
      max_q   <= '0;
      sum_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      o_ch_q  <= '0;
      o_min_q <= '0;
      o_max_q <= '0;
      o_sum_q <= '0;
      o_rep_q <= 1'b0;
      o_avg_q <= '0;
      o_blw_q <= '0;
      o_abv_q <= '0;
    end else begin
      state_q <= state_d;
      spb_q   <= spb_d;
      ov_q    <= ov_d;
      ch_q    <= ch_d;
      smp_q   <= smp_d;
      first_q <= first_d;
      last_q  <= last_d;
      min_q   <= min_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      o_ch_q  <= o_ch_d;
      o_min_q <= o_min_d;
      o_max_q <= o_max_d;
      o_sum_q <= o_sum_d;
      o_rep_q <= o_rep_d;
      o_avg_q <= o_avg_d;
      o_blw_q <= o_blw_d;
      o_abv_q <= o_abv_d;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.channel_out   = o_ch_q;
  assign out_o.minimum       = o_min_q;
  assign out_o.maximum       = o_max_q;
  assign out_o.running_sum   = o_sum_q;
  assign out_o.report_valid  = o_rep_q;
  assign out_o.average       = o_avg_q;
  assign out_o.below_average = o_blw_q;
  assign out_o.above_average = o_abv_q;

endmodule
`default_nettype wire

[hdl/pcmm_checker.sv]
// Port-level checks for per_channel_min_max_mean, bound to the top level.
// Depends on pcmm_pkg and per_channel_min_max_mean.
`default_nettype none
module pcmm_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_i,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic                                report_valid_i,
  input wire logic [pcmm_pkg::SampleWidth-1:0]    minimum_i,
  input wire logic [pcmm_pkg::SampleWidth-1:0]    maximum_i,
  input wire logic [pcmm_pkg::SumWidth-1:0]       running_sum_i,
  input wire logic [pcmm_pkg::SampleWidth-1:0]    average_i,
  input wire logic [pcmm_pkg::SampleWidth-1:0]    below_average_i,
  input wire logic [pcmm_pkg::SampleWidth-1:0]    above_average_i
);

  // one request in flight: ready drops right after acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(running_sum_i)
      && $stable(minimum_i) && $stable(maximum_i) && $stable(average_i))
    else $error("stalled result changed");

  a_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !report_valid_i |->
      average_i == '0 && below_average_i == '0 && above_average_i == '0)
    else $error("report fields set without report");

  a_distances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && report_valid_i |->
      below_average_i == ((average_i > minimum_i) ? average_i - minimum_i : '0) &&
      above_average_i == ((maximum_i > average_i) ? maximum_i - average_i : '0))
    else $error("distance fields inconsistent with average");

endmodule

bind per_channel_min_max_mean pcmm_checker u_pcmm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .report_valid_i  (out_o.report_valid),
  .minimum_i       (out_o.minimum),
  .maximum_i       (out_o.maximum),
  .running_sum_i   (out_o.running_sum),
  .average_i       (out_o.average),
  .below_average_i (out_o.below_average),
  .above_average_i (out_o.above_average)
);
`default_nettype wire

[sim/per_channel_min_max_mean_tb.sv]
// Testbench for per_channel_min_max_mean: drives channel samples and checks every
// result against a built-in per-channel min/max/sum/average predictor.
// Depends on pcmm_pkg, pcmm_if.sv and the block itself.
`default_nettype none
module per_channel_min_max_mean_tb;
  import pcmm_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int PrintLimit    = 50;
  localparam logic [ApbAddrWidth-1:0] BlockSizeAddr =
    ApbAddrWidth'(4 * int'(RegSamplesPerBlock));

  typedef enum {IdleOff, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    logic [ChanWidth-1:0]   channel;
    logic [SampleWidth-1:0] minimum;
    logic [SampleWidth-1:0] maximum;
    logic [SumWidth-1:0]    sum;
    logic                   report_valid;
    logic [SampleWidth-1:0] average;
    logic [SampleWidth-1:0] below;
    logic [SampleWidth-1:0] above;
  } stats_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata, prdata;

  pcmm_in_if  in_if ();
  pcmm_out_if out_if ();

  per_channel_min_max_mean i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [SampleWidth-1:0] min_tab [ChannelCount];
  logic [SampleWidth-1:0] max_tab [ChannelCount];
  logic [SumWidth-1:0]    sum_tab [ChannelCount];
  logic                   chan_seen [ChannelCount];
  logic [CfgWidth-1:0]    block_size;

  stats_t expected_stats [$];
  int errors        = 0;
  int sent_count    = 0;
  int results_seen  = 0;
  int reports_seen  = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PrintLimit)
      $display("MISMATCH %s: got %0h expected %0h (request %0d)", what, got, want,
               results_seen);
    errors++;
  endtask

  function automatic stats_t fold_sample(input logic [ChanWidth-1:0] ch,
                                         input logic [SampleWidth-1:0] smp,
                                         input logic first, input logic last);
    stats_t r;
    logic [SumWidth-1:0] divisor;
    logic [SumWidth-1:0] quot;
    if (first) begin
      min_tab[ch] = SampleMax;
      max_tab[ch] = '0;
      sum_tab[ch] = '0;
    end
    if (smp < min_tab[ch]) min_tab[ch] = smp;
    if (smp > max_tab[ch]) max_tab[ch] = smp;
    sum_tab[ch] = sum_tab[ch] + SumWidth'(smp);
    chan_seen[ch] = 1'b1;
    r = '0;
    r.channel      = ch;
    r.minimum      = min_tab[ch];
    r.maximum      = max_tab[ch];
    r.sum          = sum_tab[ch];
    r.report_valid = last;
    if (last) begin
      divisor = (block_size == '0) ? 1 : SumWidth'(block_size);
      quot = sum_tab[ch] / divisor;
      if (quot > SumWidth'(SampleMax)) quot = SumWidth'(SampleMax);
      r.average = quot[SampleWidth-1:0];
      r.below   = (r.average > r.minimum) ? r.average - r.minimum : '0;
      r.above   = (r.maximum > r.average) ? r.maximum - r.average : '0;
    end
    return r;
  endfunction

  function automatic logic [SampleWidth-1:0] rand_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return SampleMax;
      2: return SampleWidth'($urandom_range(255));
      3: return SampleWidth'($urandom_range(16'hffff, 16'hff00));
      default: return SampleWidth'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [ChanWidth-1:0] ch,
                             input logic [SampleWidth-1:0] smp,
                             input logic first, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.channel    = ch;
    in_if.sample     = smp;
    in_if.first_pass = first;
    in_if.last_pass  = last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_stats.push_back(fold_sample(ch, smp, first, last));
    sent_count++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_stats.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [ApbDataWidth-1:0] wdata,
                            output logic [ApbDataWidth-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = BlockSizeAddr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_block_size(input logic [CfgWidth-1:0] value);
    logic [ApbDataWidth-1:0] rd;
    wait_drained();
    repeat (4) @(negedge clk_i);
    apb_access(1'b1, ApbDataWidth'(value), rd);
    block_size = value;
    apb_access(1'b0, '0, rd);
    if (rd !== ApbDataWidth'(value)) report_mismatch("samples_per_block readback", rd,
                                                      ApbDataWidth'(value));
  endtask

  task automatic set_idling(input idle_mode_e mode);
    idle_pct  = (mode == IdleSender || mode == IdleReceiver) ? 68 : 0;
    stall_pct = idle_pct;
    if (mode == IdleSender) stall_pct = 0;
    if (mode == IdleReceiver) idle_pct = 0;
    if (mode == IdleBoth) begin
      idle_pct  = 13;
      stall_pct = 13;
    end
  endtask

  // one well-formed block: every pass over a random set of channels
  task automatic send_block();
    logic [ChannelCount-1:0] mask;
    int passes;
    passes = (block_size == '0) ? 1 : int'(block_size);
    mask = ChannelCount'($urandom_range(16'hffff, 1));
    for (int p = 1; p <= passes; p++)
      for (int ch = 0; ch < ChannelCount; ch++)
        if (mask[ch])
          send_sample(ChanWidth'(ch), rand_sample(), p == 1, p == passes);
  endtask

  // stray requests; an unwritten channel always starts with first_pass
  task automatic send_noise(input int count);
    logic [ChanWidth-1:0] ch;
    for (int i = 0; i < count; i++) begin
      ch = ChanWidth'($urandom_range(ChannelCount - 1));
      send_sample(ch, rand_sample(), !chan_seen[ch] || ($urandom_range(3) == 0),
                  $urandom_range(1) == 1);
    end
  endtask

  task automatic test_register_reset();
    logic [ApbDataWidth-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== ApbDataWidth'(1)) report_mismatch("samples_per_block after reset", rd, 1);
    block_size = 1;
  endtask

  task automatic test_directed_cases();
    set_idling(IdleOff);
    write_block_size(1);
    send_sample(4'd0, 16'h0000, 1'b1, 1'b1);
    send_sample(4'd15, 16'hffff, 1'b1, 1'b1);
    send_sample(4'd1, 16'hffff, 1'b1, 1'b0);   // no report fields
    send_sample(4'd1, 16'hffff, 1'b0, 1'b1);   // average saturates
    send_sample(4'd2, 16'd100, 1'b1, 1'b0);
    send_sample(4'd2, 16'd200, 1'b0, 1'b1);    // average above max
    send_sample(4'b1010, 16'haaaa, 1'b1, 1'b0);
    send_sample(4'b0101, 16'h5555, 1'b1, 1'b0);
    send_sample(4'b1010, 16'h5555, 1'b0, 1'b1);
    send_sample(4'b0101, 16'haaaa, 1'b0, 1'b1);
    write_block_size(0);                       // zero divisor acts as one
    send_sample(4'd3, 16'd1234, 1'b1, 1'b1);
    send_sample(4'd3, 16'd10, 1'b0, 1'b1);
    write_block_size(16'hffff);
    send_sample(4'd4, 16'hffff, 1'b1, 1'b0);
    send_sample(4'd4, 16'hffff, 1'b0, 1'b1);   // average below min
    send_sample(4'd4, 16'h0000, 1'b0, 1'b1);
    send_sample(4'd0, 16'h8000, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_stall();
    write_block_size(3);
    set_idling(IdleOff);
    hold_left = 200;
    send_noise(10);
    wait_drained();
  endtask

  task automatic test_drained_pause();
    set_idling(IdleBoth);
    send_noise(6);
    wait_drained();
    repeat (10) @(negedge clk_i);
    send_noise(6);
    wait_drained();
  endtask

  task automatic run_random_phase(input idle_mode_e mode, input logic [CfgWidth-1:0] size,
                                  input int goal, input logic blocks_ok);
    int start;
    write_block_size(size);
    set_idling(mode);
    start = sent_count;
    while (sent_count - start < goal) begin
      if (blocks_ok && $urandom_range(3) != 0) send_block();
      else send_noise($urandom_range(4, 1));
    end
    wait_drained();
  endtask

  task automatic test_random_blocks();
    run_random_phase(IdleOff, 4, 90, 1'b1);
    run_random_phase(IdleSender, 1, 90, 1'b1);
    run_random_phase(IdleReceiver, 7, 90, 1'b1);
    run_random_phase(IdleBoth, 2, 90, 1'b1);
    run_random_phase(IdleBoth, 16'hffff, 40, 1'b0);
  endtask

  // result sink: ready pattern, plus a counted long hold when requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    stats_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.report_valid) reports_seen++;
      if (expected_stats.size() == 0) begin
        report_mismatch("result without request", 0, 0);
      end else begin
        want = expected_stats.pop_front();
        if (out_if.channel_out !== want.channel)
          report_mismatch("channel_out", out_if.channel_out, want.channel);
        if (out_if.minimum !== want.minimum)
          report_mismatch("minimum", out_if.minimum, want.minimum);
        if (out_if.maximum !== want.maximum)
          report_mismatch("maximum", out_if.maximum, want.maximum);
        if (out_if.running_sum !== want.sum)
          report_mismatch("running_sum", out_if.running_sum, want.sum);
        if (out_if.report_valid !== want.report_valid)
          report_mismatch("report_valid", out_if.report_valid, want.report_valid);
        if (out_if.average !== want.average)
          report_mismatch("average", out_if.average, want.average);
        if (out_if.below_average !== want.below)
          report_mismatch("below_average", out_if.below_average, want.below);
        if (out_if.above_average !== want.above)
          report_mismatch("above_average", out_if.above_average, want.above);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no request moved for %0d cycles", WatchdogLimit);
      $display("per_channel_min_max_mean_tb failed");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.channel    = '0;
    in_if.sample     = '0;
    in_if.first_pass = 1'b0;
    in_if.last_pass  = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    block_size       = 1;
    for (int i = 0; i < ChannelCount; i++) begin
      min_tab[i]   = '0;
      max_tab[i]   = '0;
      sum_tab[i]   = '0;
      chan_seen[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_reset();
    test_directed_cases();
    test_output_stall();
    test_drained_pause();
    test_random_blocks();

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (expected_stats.size() != 0)
      report_mismatch("results still outstanding", expected_stats.size(), 0);
    $display("covered %0d requests, %0d results, %0d with average report", sent_count,
             results_seen, reports_seen);
    $display("block sizes 0, 1, 2, 3, 4, 7 and 65535; long output stall; drained pause");
    if (errors == 0) begin
      $display("per_channel_min_max_mean_tb passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("per_channel_min_max_mean_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
